// File: hdl/bucketed_peak_meter_core_macros.svh
// Assertion macros for the bucketed peak meter checker.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef BUCKETED_PEAK_METER_CORE_MACROS_SVH
`define BUCKETED_PEAK_METER_CORE_MACROS_SVH

// Same-cycle implication.
`define BPM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/bpm_pkg.sv
// Shared constants, register codes and stage types of the bucketed peak meter.
// No dependencies; every other file of the block but the macros header uses it by scoped names.
package bpm_pkg;

	localparam int HISTORY_DEPTH = 256;
	localparam int NUM_LANES     = 2;

	localparam int SAMPLE_W   = 32;
	localparam int MAG_W      = 31;
	localparam int FILL_W     = 16;
	localparam int BUCKET_W   = 32;
	localparam int CHAN_W     = 2;
	localparam int ENTRY_W    = BUCKET_W + MAG_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

	localparam logic REQ_READ = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_COUNT = 1'b0,
		CFG_BUCKET_FRAMES = 1'b1
	} cfg_reg_t;

	localparam logic [CHAN_W-1:0] CHAN_RESET   = 2'd2;
	localparam logic [FILL_W-1:0] FRAMES_RESET = 16'd1200;

	// Payload carried down the pipeline next to the address unit.
	typedef struct packed {
		logic                             is_read;
		logic                             block_end;
		logic [NUM_LANES-1:0][MAG_W-1:0]  mag;
	} stage_t;

	// Result of a frame request from the merge stage.
	typedef struct packed {
		logic                 published;
		logic [BUCKET_W-1:0]  bucket_index;
		logic [MAG_W-1:0]     peak;
	} frame_res_t;

endpackage

// File: hdl/bpm_lane.sv
// One channel lane: magnitude of an IEEE-single sample, zero when not finite
// or when the lane is disabled. Depends on bpm_pkg.
module bpm_lane (
	input  logic [bpm_pkg::SAMPLE_W-1:0] sample,
	input  logic                         en,
	output logic [bpm_pkg::MAG_W-1:0]    mag
);

	logic finite;

	// exponent all ones means inf or NaN
	assign finite = (sample[30:23] != bpm_pkg::EXP_ALL_ONES);
	assign mag    = (en && finite) ? sample[bpm_pkg::MAG_W-1:0] : '0;

endmodule

// File: hdl/bpm_mod.sv
// Query index modulo the history depth: reciprocal multiply, back-multiply,
// subtract, then one correcting subtract. Three register stages. Uses bpm_pkg.
module bpm_mod #(
	parameter int DEPTH = bpm_pkg::HISTORY_DEPTH
) (
	input  logic                         clk,
	input  logic                         adv,
	input  logic [bpm_pkg::BUCKET_W-1:0] q_in,
	output logic [bpm_pkg::BUCKET_W-1:0] q_s3,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] r_s3
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [32:0] Recip  = 33'((65'd1 << 32) / DEPTH);
	localparam logic [31:0] DepthW = 32'(DEPTH);
	localparam logic [AW:0] DepthR = (AW + 1)'(DEPTH);

	logic [64:0]  prod1;
	logic [31:0]  est_s1, q_s1, q_s2, prod_s2, diff;
	logic [AW:0]  diff_s3;

	// quotient estimate, low by at most one
	assign prod1 = 65'(q_in) * 65'(Recip);
	assign diff  = q_s2 - prod_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1    <= q_in;
			est_s1  <= prod1[63:32];
			q_s2    <= q_s1;
			prod_s2 <= est_s1 * DepthW;
			q_s3    <= q_s2;
			diff_s3 <= diff[AW:0];
		end
	end

	// remainder is below twice the depth here
	always_comb begin
		if (diff_s3 >= DepthR) begin
			r_s3 = AW'(diff_s3 - DepthR);
		end else begin
			r_s3 = diff_s3[AW-1:0];
		end
	end

endmodule

// File: hdl/bpm_history.sv
// Peak history memory: one write port, one registered read port, and a
// clearing pass over all entries after reset. Uses bpm_pkg.
module bpm_history #(
	parameter int DEPTH = bpm_pkg::HISTORY_DEPTH
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [bpm_pkg::ENTRY_W-1:0]                  wr_data,
	input  logic                                         rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [bpm_pkg::ENTRY_W-1:0]                  rd_data,
	output logic                                         clearing
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

	logic [bpm_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic                        clearing_q;
	logic [AW-1:0]               clr_ptr_q;

	assign clearing = clearing_q;

	// clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_ptr_q  <= '0;
		end else if (clearing_q) begin
			if (clr_ptr_q == LastAddr) begin
				clearing_q <= 1'b0;
			end
			clr_ptr_q <= clr_ptr_q + 1'b1;
		end
	end

	// array write and registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_ptr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/bpm_merge.sv
// Merge stage: folds the lane magnitudes into the running peak, counts the
// bucket fill and decides when a bucket is published. Uses bpm_pkg.
module bpm_merge #(
	parameter int DEPTH = bpm_pkg::HISTORY_DEPTH
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             fire,
	input  logic                                             block_end,
	input  logic [bpm_pkg::NUM_LANES-1:0][bpm_pkg::MAG_W-1:0] mag,
	input  logic [bpm_pkg::FILL_W-1:0]                       bucket_frames,
	output bpm_pkg::frame_res_t                              res,
	output logic                                             wr_en,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     wr_addr,
	output logic [bpm_pkg::ENTRY_W-1:0]                      wr_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

	logic [bpm_pkg::MAG_W-1:0]    peak_q, peak_new;
	logic [bpm_pkg::FILL_W-1:0]   fill_q, fill_after;
	logic [bpm_pkg::BUCKET_W-1:0] number_q;
	logic [AW-1:0]                slot_q;
	logic [bpm_pkg::FILL_W:0]     limit, next_fill;
	logic                         close, partial;

	// peak over the lanes
	always_comb begin
		peak_new = peak_q;
		for (int i = 0; i < bpm_pkg::NUM_LANES; i++) begin
			if (mag[i] > peak_new) begin
				peak_new = mag[i];
			end
		end
	end

	// bucket close and partial publish
	assign limit      = (bucket_frames == '0) ? {1'b1, {bpm_pkg::FILL_W{1'b0}}}
	                                          : {1'b0, bucket_frames};
	assign next_fill  = {1'b0, fill_q} + 1'b1;
	assign close      = (next_fill >= limit);
	assign fill_after = close ? '0 : next_fill[bpm_pkg::FILL_W-1:0];
	assign partial    = block_end && (fill_after != '0);

	assign res.published    = close || partial;
	assign res.bucket_index = number_q;
	assign res.peak         = peak_new;

	assign wr_en   = fire && (close || partial);
	assign wr_addr = slot_q;
	assign wr_data = {number_q + 1'b1, peak_new};

	// bucket state; the slot restarts with the bucket number when it wraps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q   <= '0;
			fill_q   <= '0;
			number_q <= '0;
			slot_q   <= '0;
		end else if (fire) begin
			fill_q <= fill_after;
			if (close) begin
				peak_q   <= '0;
				number_q <= number_q + 1'b1;
				slot_q   <= (slot_q == LastSlot || number_q == '1) ? '0 : slot_q + 1'b1;
			end else begin
				peak_q <= peak_new;
			end
		end
	end

endmodule

// File: hdl/bucketed_peak_meter_core.sv
// Bucketed peak meter: request to result is four register stages (three
// address-unit stages that carry the lane magnitudes, then the output register).
// Throughput is one request per cycle while the output is not stalled, bounded by
// the peak and fill update in the merge stage and the one write and one read port of the history memory.
// Reset is asynchronous; afterwards a clearing pass over all HISTORY_DEPTH entries
// zeroes the history while in_ready stays low.
module bucketed_peak_meter_core #(
	parameter int HISTORY_DEPTH = bpm_pkg::HISTORY_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [bpm_pkg::SAMPLE_W-1:0]   sample_left,
	input  logic [bpm_pkg::SAMPLE_W-1:0]   sample_right,
	input  logic                           frame_stored,
	input  logic                           block_end,
	input  logic [bpm_pkg::BUCKET_W-1:0]   query_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           published,
	output logic [bpm_pkg::BUCKET_W-1:0]   bucket_index,
	output logic [bpm_pkg::MAG_W-1:0]      peak_bits,
	output logic                           hit,
	input  logic                           cfg_we,
	input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	logic [bpm_pkg::CHAN_W-1:0]   chan_cnt_q, chans_eff;
	logic [bpm_pkg::FILL_W-1:0]   bucket_frames_q;

	logic                         adv, accept, clearing;
	logic                         valid_s1, valid_s2, valid_s3;
	bpm_pkg::stage_t              stage_in, stage_s1, stage_s2, stage_s3;
	logic [bpm_pkg::NUM_LANES-1:0][bpm_pkg::SAMPLE_W-1:0] lane_sample;
	logic [bpm_pkg::NUM_LANES-1:0] lane_en;

	logic [bpm_pkg::BUCKET_W-1:0] query_s3;
	logic [AW-1:0]                rd_addr, wr_addr;
	logic [bpm_pkg::ENTRY_W-1:0]  wr_data, rd_data;
	logic                         wr_en, rd_en, frame_fire;
	bpm_pkg::frame_res_t          frame_res;

	logic                         out_valid_q, out_read_q, out_pub_q;
	logic [bpm_pkg::BUCKET_W-1:0] out_index_q;
	logic [bpm_pkg::MAG_W-1:0]    out_peak_q;
	logic [bpm_pkg::BUCKET_W:0]   out_tag_exp_q;
	logic                         tag_match;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q      <= bpm_pkg::CHAN_RESET;
			bucket_frames_q <= bpm_pkg::FRAMES_RESET;
		end else if (cfg_we) begin
			unique case (bpm_pkg::cfg_reg_t'(cfg_index))
				bpm_pkg::CFG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[bpm_pkg::CHAN_W-1:0];
				bpm_pkg::CFG_BUCKET_FRAMES: bucket_frames_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the output register is free or drained
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && !clearing;
	assign accept   = in_valid && in_ready;

	// channel lanes; three channels count as two
	assign chans_eff      = (chan_cnt_q > 2'd2) ? 2'd2 : chan_cnt_q;
	assign lane_sample[0] = sample_left;
	assign lane_sample[1] = sample_right;

	for (genvar i = 0; i < bpm_pkg::NUM_LANES; i++) begin : g_lane
		assign lane_en[i] = frame_stored && (bpm_pkg::CHAN_W'(i) < chans_eff);
		bpm_lane u_lane (
			.sample (lane_sample[i]),
			.en     (lane_en[i]),
			.mag    (stage_in.mag[i])
		);
	end

	assign stage_in.is_read   = (req_type == bpm_pkg::REQ_READ);
	assign stage_in.block_end = block_end;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s1 <= stage_in;
			stage_s2 <= stage_s1;
			stage_s3 <= stage_s2;
		end
	end

	// history address of a read request
	bpm_mod #(
		.DEPTH (HISTORY_DEPTH)
	) u_mod (
		.clk  (clk),
		.adv  (adv),
		.q_in (query_index),
		.q_s3 (query_s3),
		.r_s3 (rd_addr)
	);

	assign frame_fire = adv && valid_s3 && !stage_s3.is_read;
	assign rd_en      = adv && valid_s3 && stage_s3.is_read;

	bpm_merge #(
		.DEPTH (HISTORY_DEPTH)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (frame_fire),
		.block_end     (stage_s3.block_end),
		.mag           (stage_s3.mag),
		.bucket_frames (bucket_frames_q),
		.res           (frame_res),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data)
	);

	bpm_history #(
		.DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			out_read_q    <= stage_s3.is_read;
			out_pub_q     <= stage_s3.is_read ? 1'b0 : frame_res.published;
			out_index_q   <= stage_s3.is_read ? query_s3 : frame_res.bucket_index;
			out_peak_q    <= frame_res.peak;
			out_tag_exp_q <= {1'b0, query_s3} + 1'b1;
		end
	end

	// a read hits when the stored tag is the query plus one, in 33 bits
	assign tag_match = ({1'b0, rd_data[bpm_pkg::ENTRY_W-1:bpm_pkg::MAG_W]} == out_tag_exp_q);

	assign out_valid    = out_valid_q;
	assign published    = out_pub_q;
	assign bucket_index = out_index_q;
	assign hit          = out_read_q && tag_match;
	assign peak_bits    = out_read_q ? (tag_match ? rd_data[bpm_pkg::MAG_W-1:0] : '0)
	                                 : out_peak_q;

endmodule

// File: hdl/bpm_checker.sv
// Port-level checks of the bucketed peak meter, bound to the top level.
// Depends on bpm_pkg and bucketed_peak_meter_core_macros.svh.
`include "bucketed_peak_meter_core_macros.svh"

module bpm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           published,
	input logic [bpm_pkg::BUCKET_W-1:0]   bucket_index,
	input logic [bpm_pkg::MAG_W-1:0]      peak_bits,
	input logic                           hit
);

	// a stalled result holds
	`BPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bucket_index) && $stable(peak_bits) && $stable(hit) && $stable(published), "result changed while stalled")

	// a request that publishes is a frame, never a read hit
	`BPM_ASSERT_IMPL(a_pub_no_hit, out_valid && published, !hit, "published result also hit")

	// the all-ones query can never match a stored tag
	`BPM_ASSERT_IMPL(a_hit_index, out_valid && hit, bucket_index != 32'hFFFFFFFF, "hit on all-ones query")

	// only finite magnitudes reach the peak or the history
	`BPM_ASSERT_IMPL(a_peak_finite, out_valid, peak_bits[30:23] != bpm_pkg::EXP_ALL_ONES, "non-finite peak")

endmodule

bind bucketed_peak_meter_core bpm_checker u_bpm_checker (.*);

// File: bench/tb_bucketed_peak_meter_core.sv
// Testbench for bucketed_peak_meter_core: directed and random requests, a request-level
// predictor of peak, bucket and history state, and a field-by-field result checker.
// Depends on bpm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_bucketed_peak_meter_core;

	localparam int   PIPE_LATENCY   = 4;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   HOLD_CYCLES    = 150;
	localparam int   HIST_AW        = (bpm_pkg::HISTORY_DEPTH > 1) ?
	                                  $clog2(bpm_pkg::HISTORY_DEPTH) : 1;
	localparam logic REQ_FRAME      = ~bpm_pkg::REQ_READ;

	typedef struct packed {
		logic                         req_type;
		logic [bpm_pkg::SAMPLE_W-1:0] left;
		logic [bpm_pkg::SAMPLE_W-1:0] right;
		logic                         stored;
		logic                         blk_end;
		logic [bpm_pkg::BUCKET_W-1:0] query;
	} meter_req_t;

	typedef struct packed {
		logic                         published;
		logic [bpm_pkg::BUCKET_W-1:0] bucket;
		logic [bpm_pkg::MAG_W-1:0]    peak;
		logic                         hit;
	} meter_res_t;

	// DUT signals
	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic                           req_type;
	logic [bpm_pkg::SAMPLE_W-1:0]   sample_left;
	logic [bpm_pkg::SAMPLE_W-1:0]   sample_right;
	logic                           frame_stored;
	logic                           block_end;
	logic [bpm_pkg::BUCKET_W-1:0]   query_index;
	logic                           out_valid;
	logic                           out_ready;
	logic                           published;
	logic [bpm_pkg::BUCKET_W-1:0]   bucket_index;
	logic [bpm_pkg::MAG_W-1:0]      peak_bits;
	logic                           hit;
	logic                           cfg_we;
	logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data;

	// Shadow of the meter: registers, bucket state and tagged history
	logic [bpm_pkg::CHAN_W-1:0]   chan_cfg   = bpm_pkg::CHAN_RESET;
	logic [bpm_pkg::FILL_W-1:0]   frames_cfg = bpm_pkg::FRAMES_RESET;
	logic [bpm_pkg::MAG_W-1:0]    run_peak   = '0;
	logic [bpm_pkg::FILL_W-1:0]   fill_count = '0;
	logic [bpm_pkg::BUCKET_W-1:0] bucket_no  = '0;
	logic [63:0]                  hist_shadow [bpm_pkg::HISTORY_DEPTH];

	meter_res_t  results_due [$];

	bit          idling_on     = 1'b1;
	int          sink_hold_len = 0;
	int unsigned mismatch_count;
	int unsigned results_seen;
	int unsigned requests_sent;
	int unsigned reads_sent;
	int unsigned history_writes;
	int unsigned idle_cycles;

	bucketed_peak_meter_core uut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		foreach (hist_shadow[i])
			hist_shadow[i] = '0;
	end

	// Mismatch log: one line each
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("%0t: %s mismatch at result %0d: got %h, wanted %h",
			$realtime, what, results_seen, got, want);
	endtask

	// Mostly no gap, some short ones, a few long ones
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// History entry that holds a bucket number
	function automatic logic [HIST_AW-1:0] hist_slot(input logic [bpm_pkg::BUCKET_W-1:0] b);
		return HIST_AW'(b % bpm_pkg::HISTORY_DEPTH);
	endfunction

	// Magnitude with the sign dropped; Inf and NaN never raise the peak
	function automatic logic [bpm_pkg::MAG_W-1:0] finite_magnitude(
			input logic [bpm_pkg::SAMPLE_W-1:0] s);
		if (s[30:23] == bpm_pkg::EXP_ALL_ONES)
			return '0;
		return s[bpm_pkg::MAG_W-1:0];
	endfunction

	task automatic record_bucket(inout meter_res_t res);
		hist_shadow[hist_slot(bucket_no)] = {bucket_no + 32'd1, 1'b0, run_peak};
		res.published = 1'b1;
		res.bucket    = bucket_no;
		res.peak      = run_peak;
		history_writes++;
	endtask

	// Apply one accepted request to the shadow state and queue its result
	task automatic advance_peak_meter(input meter_req_t r);
		meter_res_t                res;
		logic [63:0]               slot;
		int unsigned               lanes;
		logic [16:0]               bucket_len;
		logic [16:0]               next_fill;
		logic [bpm_pkg::MAG_W-1:0] mag_l;
		logic [bpm_pkg::MAG_W-1:0] mag_r;
		res = '0;
		requests_sent++;
		if (r.req_type == bpm_pkg::REQ_READ) begin
			reads_sent++;
			slot = hist_shadow[hist_slot(r.query)];
			res.bucket = r.query;
			// tag is bucket + 1, compared in 33 bits so an all-ones query never hits
			if ({1'b0, slot[63:32]} == {1'b0, r.query} + 33'd1) begin
				res.hit  = 1'b1;
				res.peak = slot[bpm_pkg::MAG_W-1:0];
			end
		end else begin
			lanes = (chan_cfg > 2'd2) ? 2 : chan_cfg;
			if (r.stored) begin
				mag_l = finite_magnitude(r.left);
				mag_r = finite_magnitude(r.right);
				if (lanes >= 1 && mag_l > run_peak)
					run_peak = mag_l;
				if (lanes >= 2 && mag_r > run_peak)
					run_peak = mag_r;
			end
			// a size of zero means 65536 frames
			bucket_len = (frames_cfg == '0) ? 17'h10000 : {1'b0, frames_cfg};
			next_fill  = {1'b0, fill_count} + 17'd1;
			if (next_fill >= bucket_len) begin
				record_bucket(res);
				bucket_no++;
				fill_count = '0;
				run_peak   = '0;
			end else begin
				fill_count = next_fill[bpm_pkg::FILL_W-1:0];
			end
			// block end publishes the open bucket, which keeps filling
			if (r.blk_end && fill_count != '0)
				record_bucket(res);
			if (!res.published) begin
				res.bucket = bucket_no;
				res.peak   = run_peak;
			end
		end
		results_due.push_back(res);
	endtask

	// Drive one request, hold it until accepted, then maybe idle
	task automatic send_request(input meter_req_t r);
		int unsigned gap;
		in_valid     <= 1'b1;
		req_type     <= r.req_type;
		sample_left  <= r.left;
		sample_right <= r.right;
		frame_stored <= r.stored;
		block_end    <= r.blk_end;
		query_index  <= r.query;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		advance_peak_meter(r);
		gap = idling_on ? idle_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every queued result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_register(input bpm_pkg::cfg_reg_t idx,
			input logic [bpm_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			bpm_pkg::CFG_CHANNEL_COUNT: chan_cfg   = value[bpm_pkg::CHAN_W-1:0];
			bpm_pkg::CFG_BUCKET_FRAMES: frames_cfg = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [bpm_pkg::CFG_DATA_W-1:0] chans,
			input logic [bpm_pkg::CFG_DATA_W-1:0] frames);
		drain_results();
		write_register(bpm_pkg::CFG_CHANNEL_COUNT, chans);
		write_register(bpm_pkg::CFG_BUCKET_FRAMES, frames);
	endtask

	function automatic meter_req_t frame_req(input logic [31:0] l, input logic [31:0] r,
			input logic stored, input logic blk_end);
		return '{req_type: REQ_FRAME, left: l, right: r, stored: stored,
			blk_end: blk_end, query: $urandom};
	endfunction

	function automatic meter_req_t read_req(input logic [31:0] q);
		return '{req_type: bpm_pkg::REQ_READ, left: $urandom, right: $urandom,
			stored: 1'($urandom), blk_end: 1'($urandom), query: q};
	endfunction

	// Sample mix: Inf/NaN, zero/denormal, largest finite, mid range, raw random
	function automatic logic [bpm_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0:       return {1'($urandom), bpm_pkg::EXP_ALL_ONES, 23'($urandom)};
			1:       return {1'($urandom), 8'h00, 23'($urandom)};
			2:       return {1'($urandom), 31'h7F7F_FFFF};
			3, 4, 5: return {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Queries lean toward recent buckets so hits and overwritten entries both occur
	function automatic meter_req_t rand_request();
		meter_req_t  r;
		logic [31:0] q;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: q = bucket_no - $urandom_range(0, 40);
			5, 6:          q = bucket_no - $urandom_range(0, 700);
			7:             q = $urandom;
			8:             q = 32'hFFFF_FFFF;
			default:       q = bucket_no + $urandom_range(0, 3);
		endcase
		r.req_type = ($urandom_range(0, 3) == 0) ? bpm_pkg::REQ_READ : REQ_FRAME;
		r.left     = rand_sample();
		r.right    = rand_sample();
		r.stored   = ($urandom_range(0, 4) != 0);
		r.blk_end  = ($urandom_range(0, 7) == 0);
		r.query    = q;
		return r;
	endfunction

	// Reset configuration: cleared history, stereo, dropped frame, partial bucket
	task automatic test_default_config();
		send_request(read_req(32'd0));
		send_request(read_req(32'hFFFF_FFFF));
		send_request(frame_req(32'h3F80_0000, 32'hBFC0_0000, 1'b1, 1'b0));
		send_request(frame_req(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0, 1'b0));
		send_request(frame_req(32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1));
		send_request(read_req(32'd0));
		send_request(read_req(32'd1));
	endtask

	// Mono with a bucket of 65535 frames: NaN, -Inf, largest negative finite, denormal
	task automatic test_sample_edges();
		set_config(16'd1, 16'hFFFF);
		send_request(frame_req(32'h7FC0_0000, 32'h0000_0001, 1'b1, 1'b0));
		send_request(frame_req(32'hFF80_0000, 32'h7F00_0000, 1'b1, 1'b0));
		send_request(frame_req(32'hFF7F_FFFF, 32'h0000_0000, 1'b1, 1'b0));
		send_request(frame_req(32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 1'b0));
		send_request(frame_req(32'h8000_0001, 32'h0000_0000, 1'b1, 1'b1));
	endtask

	// Size zero, size lowered under the fill, close with block end, zero and three channels
	task automatic test_bucket_limits();
		set_config(16'd2, 16'd0);
		send_request(frame_req(32'h0000_0001, 32'h0040_0000, 1'b1, 1'b0));
		send_request(frame_req(32'h3F00_0000, 32'h0000_0000, 1'b1, 1'b1));
		set_config(16'd2, 16'd2);
		send_request(frame_req(32'h3F00_0000, 32'h0000_0000, 1'b1, 1'b0));
		send_request(frame_req(32'h4000_0000, 32'hC080_0000, 1'b1, 1'b1));
		send_request(frame_req(32'h3E00_0000, 32'h0000_0000, 1'b1, 1'b1));
		set_config(16'd0, 16'd3);
		send_request(frame_req(32'h7F00_0000, 32'h7F00_0000, 1'b1, 1'b0));
		send_request(frame_req(32'h4100_0000, 32'h4100_0000, 1'b1, 1'b0));
		send_request(frame_req(32'h4200_0000, 32'h4200_0000, 1'b1, 1'b0));
		set_config(16'd3, 16'd3);
		send_request(frame_req(32'h0000_0000, 32'h4000_0000, 1'b1, 1'b1));
		send_request(read_req(32'd2));
		send_request(read_req(32'd1));
	endtask

	// Long receiver hold while requests keep coming, then a full drain
	task automatic test_output_backpressure();
		set_config(16'd2, 16'd4);
		idling_on     = 1'b0;
		sink_hold_len = HOLD_CYCLES;
		repeat (40) send_request(rand_request());
		drain_results();
		idling_on = 1'b1;
	endtask

	// Random traffic over several register settings, idling on in most phases
	task automatic test_random_traffic();
		int unsigned    len;
		logic [15:0]    chans;
		logic [15:0]    frames;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       begin chans = 16'd2; frames = 16'd1;     len = 200; end
				1:       begin chans = 16'd1; frames = 16'd3;     len = 100; end
				2:       begin chans = 16'd2; frames = 16'($urandom_range(2, 9)); len = 100; end
				3:       begin chans = 16'd0; frames = 16'd1;     len = 150; end
				4:       begin chans = 16'd3; frames = 16'd7;     len = 80;  end
				5:       begin chans = 16'd2; frames = 16'd65535; len = 60;  end
				6:       begin chans = 16'd1; frames = 16'd0;     len = 60;  end
				default: begin chans = 16'd2; frames = 16'd2;     len = 50;  end
			endcase
			set_config(chans, frames);
			idling_on = (p != 1 && p != 4);
			repeat (len) send_request(rand_request());
		end
		idling_on = 1'b1;
	endtask

	// Receiver: random stalls, plus a counted hold when one is requested
	initial begin : result_sink
		int unsigned stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold_len != 0) begin
				out_ready <= 1'b0;
				repeat (sink_hold_len) @(posedge clk);
				sink_hold_len = 0;
				out_ready <= 1'b1;
			end else begin
				stall = idling_on ? idle_gap() : 0;
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each returned result with the oldest one due
	always @(posedge clk) begin : result_checker
		meter_res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (results_due.size() == 0) begin
				report_mismatch("unrequested result", bucket_index, 32'd0);
			end else begin
				want = results_due.pop_front();
				if (published !== want.published)
					report_mismatch("published", 32'(published), 32'(want.published));
				if (bucket_index !== want.bucket)
					report_mismatch("bucket_index", bucket_index, want.bucket);
				if (peak_bits !== want.peak)
					report_mismatch("peak_bits", 32'(peak_bits), 32'(want.peak));
				if (hit !== want.hit)
					report_mismatch("hit", 32'(hit), 32'(want.hit));
			end
		end
	end

	// Watchdog: end the run after too long without any handshake
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding",
				$realtime, WATCHDOG_LIMIT, results_due.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin : test_sequence
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		req_type     <= REQ_FRAME;
		sample_left  <= '0;
		sample_right <= '0;
		frame_stored <= 1'b0;
		block_end    <= 1'b0;
		query_index  <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= bpm_pkg::CFG_CHANNEL_COUNT;
		cfg_data     <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_config();
		test_sample_edges();
		test_bucket_limits();
		test_output_backpressure();
		test_random_traffic();

		drain_results();
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (results_due.size() != 0)
			report_mismatch("results never returned", 32'd0, 32'(results_due.size()));

		$display("%0d requests (%0d history reads), %0d results checked, %0d history writes",
			requests_sent, reads_sent, results_seen, history_writes);
		$display("channel counts 0 to 3, bucket sizes 1 to 65536; %0d field mismatches",
			mismatch_count);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
